### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/rtm_pkg.sv
// ----------------------------------------------------------------------------
// rtm_pkg
// types and constants of the ping round-trip matcher
// ----------------------------------------------------------------------------
package rtm_pkg;

    // ring geometry
    localparam int RECORD_DEPTH = 32;
    localparam int IDX_W        = $clog2(RECORD_DEPTH);

    typedef logic [IDX_W-1:0] t_idx;

    localparam t_idx LAST_IDX = IDX_W'(RECORD_DEPTH - 1);

    // request opcodes
    localparam logic OP_SEND = 1'b0;
    localparam logic OP_ACK  = 1'b1;

    // one request
    typedef struct packed {
        logic        op;
        logic [47:0] peer_addr;
        logic [31:0] sequence_req;
        logic [47:0] event_time;
    } t_in_req;

    // one result
    typedef struct packed {
        logic        matched;
        logic [47:0] sent_time;
        logic [47:0] round_trip;
    } t_out_res;

    // one stored ping record
    typedef struct packed {
        logic [47:0] rec_mac;
        logic [31:0] rec_seq;
        logic [47:0] rec_time;
    } t_record;

    localparam int RECORD_W = $bits(t_record);

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DIFF,
        S_DONE
    } t_state;

endpackage

### hdl/rtm_ram.sv
// ----------------------------------------------------------------------------
// rtm_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module rtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/ping_round_trip_matcher_core.sv
// Send request: stored on acceptance, result loaded in S_DONE; next request taken in S_IDLE after the load.
// Acknowledge request: the record RAM is read and compared one entry per cycle in S_SCAN,
//   lowest index first; a hit goes through S_DIFF to S_DONE, a miss reaches S_DONE after
//   index RECORD_DEPTH - 1; result loaded in S_DONE, next request taken after the load.
// One request in flight; a stalled output register delays the load and the next request.
// Reset (synchronous, active low) clears pending marks, write pointer and valids at once.
// ----------------------------------------------------------------------------
// ping_round_trip_matcher_core
// ring of ping records; sends are stored, acknowledges are matched by a
// sequential compare over the record RAM and report the round trip
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ping_round_trip_matcher_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  rtm_pkg::t_in_req  i_in_req,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output rtm_pkg::t_out_res o_out_res
);

    import rtm_pkg::*;

    t_state                  r_state, n_state;
    t_in_req                 r_item, n_item;
    t_idx                    r_wr_ptr, n_wr_ptr;
    logic [RECORD_DEPTH-1:0] r_pending, n_pending;
    t_idx                    r_rd_addr, n_rd_addr;
    t_idx                    r_cmp_idx, n_cmp_idx;
    logic                    r_cmp_vld, n_cmp_vld;
    t_out_res                r_res, n_res;
    logic                    r_out_valid, n_out_valid;
    t_out_res                r_out, n_out;

    logic                    w_ram_we;
    t_record                 w_ram_wdata;
    t_record                 w_ram_q;
    logic                    w_hit;
    logic                    w_in_acc;

    // record storage
    rtm_ram #(
        .WIDTH (RECORD_W),
        .DEPTH (RECORD_DEPTH)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_rd_addr),
        .o_rdata (w_ram_q)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    assign w_ram_wdata = '{rec_mac:  i_in_req.peer_addr,
                           rec_seq:  i_in_req.sequence_req,
                           rec_time: i_in_req.event_time};

    // shared compare of the entry read last cycle against the request
    assign w_hit = r_cmp_vld && r_pending[r_cmp_idx]
                   && (w_ram_q.rec_mac == r_item.peer_addr)
                   && (w_ram_q.rec_seq == r_item.sequence_req);

    // sequencer next state and datapath
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_wr_ptr    = r_wr_ptr;
        n_pending   = r_pending;
        n_rd_addr   = r_rd_addr;
        n_cmp_idx   = r_cmp_idx;
        n_cmp_vld   = r_cmp_vld;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_ram_we    = 1'b0;

        // result taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_req;
                    n_res  = '0;
                    if (i_in_req.op == OP_SEND) begin
                        // store record and advance ring pointer
                        w_ram_we            = 1'b1;
                        n_pending[r_wr_ptr] = 1'b1;
                        n_wr_ptr = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + IDX_W'(1);
                        n_state  = S_DONE;
                    end else begin
                        n_rd_addr = '0;
                        n_cmp_vld = 1'b0;
                        n_state   = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // issue next read while comparing the previous one
                n_cmp_vld = 1'b1;
                n_cmp_idx = r_rd_addr;
                if (r_rd_addr != LAST_IDX) begin
                    n_rd_addr = r_rd_addr + IDX_W'(1);
                end
                if (w_hit) begin
                    n_pending[r_cmp_idx] = 1'b0;
                    n_res.matched        = 1'b1;
                    n_res.sent_time      = w_ram_q.rec_time;
                    n_state              = S_DIFF;
                end else if (r_cmp_vld && (r_cmp_idx == LAST_IDX)) begin
                    n_state = S_DONE;
                end
            end
            S_DIFF: begin
                // round trip wraps modulo 2^48
                n_res.round_trip = r_item.event_time - r_res.sent_time;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_ptr    <= '0;
            r_pending   <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_ptr    <= n_wr_ptr;
            r_pending   <= n_pending;
            r_cmp_vld   <= n_cmp_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_rd_addr <= n_rd_addr;
        r_cmp_idx <= n_cmp_idx;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    // a stored send leaves its slot pending
    `ASSERT_NEXT(a_send_sets_pending, i_clk, i_rst_n,
        w_in_acc && (i_in_req.op == OP_SEND), r_pending[$past(r_wr_ptr)],
        "send request did not mark its slot pending")

    // a match clears exactly one pending mark
    `ASSERT_SAME(a_hit_clears_one, i_clk, i_rst_n,
        r_state == S_DIFF, $countones(r_pending) + 1 == $countones($past(r_pending)),
        "match did not clear exactly one pending mark")

    // results without a match carry zero times
    `ASSERT_SAME(a_miss_is_zero, i_clk, i_rst_n,
        r_out_valid && !r_out.matched, (r_out.sent_time == '0) && (r_out.round_trip == '0),
        "unmatched result carries nonzero time")

endmodule
